// File: rtl/prl_pkg.sv
`default_nettype none

package prl_pkg;

   localparam int LIST_DEPTH    = 16;
   localparam int IDX_W         = $clog2(LIST_DEPTH);
   localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
   localparam int FUNC_W        = 3;
   localparam int POS_W         = 5;
   localparam int CARD_W        = 31;
   localparam int BAL_W         = 32;
   localparam int ENTRY_COUNT_W = 5;
   localparam int ERR_W         = 2;
   // common width for comparing a request position against the count
   localparam int CMP_W         = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_INSERT     = 3'd4,
      FN_ERASE      = 3'd5
   } func_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK      = 2'd0,
      ERR_BAD_POS = 2'd1,
      ERR_FULL    = 2'd2,
      ERR_EMPTY   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE,
      ST_PLACE,
      ST_PEEK_FRONT,
      ST_PEEK_BACK,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [CARD_W-1:0]       card;
      logic signed [BAL_W-1:0] balance;
   } rec_type;

endpackage

`default_nettype wire

// File: rtl/prl_store.sv
`default_nettype none

module prl_store (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [prl_pkg::IDX_W-1:0] wr_addr,
   input  wire prl_pkg::rec_type        wr_data,
   input  wire logic [prl_pkg::IDX_W-1:0] rd_addr,
   output prl_pkg::rec_type             rd_data
);
   import prl_pkg::*;

   rec_type mem [LIST_DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/positional_record_list_unit.sv
`default_nettype none
// Steps from accept to rsp_valid: a request that changes nothing (error or unknown func)
//   runs PEEK_FRONT, PEEK_BACK, REPLY; insert/push run MOVE and PLACE first, pop/erase MOVE.
// Flow: one beat in flight; REPLY waits while rsp_stall holds the output. req_stall drops
//   at the edge that loads the result, so the next beat can go in the cycle after.
// The shift walks the record RAM one entry per cycle through its single read port.
// Reset (synchronous, active high) empties the list and drops rsp_valid; RAM is not cleared.

module positional_record_list_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [prl_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [prl_pkg::POS_W-1:0]       req_position,
   input  wire logic [prl_pkg::CARD_W-1:0]      req_card_number,
   input  wire logic signed [prl_pkg::BAL_W-1:0] req_balance,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [prl_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count,
   output logic                                 rsp_is_empty,
   output logic [prl_pkg::ERR_W-1:0]            rsp_error_code,
   output logic [prl_pkg::CARD_W-1:0]           rsp_front_card,
   output logic signed [prl_pkg::BAL_W-1:0]     rsp_front_balance,
   output logic [prl_pkg::CARD_W-1:0]           rsp_back_card,
   output logic signed [prl_pkg::BAL_W-1:0]     rsp_back_balance
);
   import prl_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [IDX_W-1:0]        src_ff, src_in;
   logic                    up_ff, up_in;
   logic                    ins_ff, ins_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]        pend_dst_ff, pend_dst_in;
   logic [IDX_W-1:0]        place_idx_ff, place_idx_in;
   rec_type                 new_rec_ff, new_rec_in;
   err_type                 err_ff, err_in;
   rec_type                 front_ff, front_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   err_type                 rsp_err_ff, rsp_err_in;
   rec_type                 rsp_front_ff, rsp_front_in;
   rec_type                 rsp_back_ff, rsp_back_in;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_wa;
   rec_type                 mem_wd;
   logic [IDX_W-1:0]        mem_ra;
   rec_type                 mem_rd;

   logic                    req_acc;
   logic                    out_free;
   logic [CMP_W-1:0]        pos_x;
   logic [CMP_W-1:0]        cnt_x;
   logic                    full;
   logic                    empty;
   logic                    do_ins;
   logic                    do_rem;
   logic [CNT_W-1:0]        tgt;
   logic [IDX_W-1:0]        back_idx;

   prl_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pos_x     = CMP_W'(req_position);
   assign cnt_x     = CMP_W'(count_ff);
   assign full      = (count_ff >= CNT_W'(LIST_DEPTH));
   assign empty     = (count_ff == '0);
   assign back_idx  = IDX_W'(count_ff - CNT_W'(1));

   // request decode
   always_comb begin
      do_ins = 1'b0;
      do_rem = 1'b0;
      tgt    = '0;
      err_in = ERR_OK;
      unique case (req_func)
         FN_PUSH_FRONT: begin
            if (full) err_in = ERR_FULL;
            else      do_ins = 1'b1;
         end
         FN_PUSH_BACK: begin
            tgt = count_ff;
            if (full) err_in = ERR_FULL;
            else      do_ins = 1'b1;
         end
         FN_POP_FRONT: begin
            if (empty) err_in = ERR_EMPTY;
            else       do_rem = 1'b1;
         end
         FN_POP_BACK: begin
            tgt = count_ff - CNT_W'(1);
            if (empty) err_in = ERR_EMPTY;
            else       do_rem = 1'b1;
         end
         FN_INSERT: begin
            tgt = CNT_W'(pos_x);
            if (full)               err_in = ERR_FULL;
            else if (pos_x > cnt_x) err_in = ERR_BAD_POS;
            else                    do_ins = 1'b1;
         end
         FN_ERASE: begin
            tgt = CNT_W'(pos_x);
            if (empty)               err_in = ERR_EMPTY;
            else if (pos_x >= cnt_x) err_in = ERR_BAD_POS;
            else                     do_rem = 1'b1;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      src_in       = src_ff;
      up_in        = up_ff;
      ins_in       = ins_ff;
      pend_vld_in  = 1'b0;
      pend_dst_in  = pend_dst_ff;
      place_idx_in = place_idx_ff;
      new_rec_in   = new_rec_ff;
      front_in     = front_ff;
      mem_we       = 1'b0;
      mem_wa       = pend_dst_ff;
      mem_wd       = mem_rd;
      mem_ra       = back_idx;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_front_in = rsp_front_ff;
      rsp_back_in  = rsp_back_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               new_rec_in.card    = req_card_number;
               new_rec_in.balance = req_balance;
               place_idx_in       = IDX_W'(tgt);
               ins_in             = do_ins;
               up_in              = do_ins;
               if (do_ins) begin
                  left_in  = count_ff - tgt;
                  src_in   = back_idx;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  left_in  = count_ff - tgt - CNT_W'(1);
                  src_in   = IDX_W'(tgt + CNT_W'(1));
               end
               if (do_rem) count_in = count_ff - CNT_W'(1);
               state_in = (do_ins || do_rem) ? ST_MOVE : ST_PEEK_FRONT;
            end
         end
         ST_MOVE: begin
            // read one entry per cycle, write it one slot over on the next
            mem_ra = src_ff;
            if (pend_vld_ff) mem_we = 1'b1;
            if (left_ff != '0) begin
               left_in     = left_ff - CNT_W'(1);
               src_in      = up_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
               pend_vld_in = 1'b1;
               pend_dst_in = up_ff ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
            end else if (!pend_vld_ff) begin
               state_in = ins_ff ? ST_PLACE : ST_PEEK_FRONT;
            end
         end
         ST_PLACE: begin
            mem_we   = 1'b1;
            mem_wa   = place_idx_ff;
            mem_wd   = new_rec_ff;
            state_in = ST_PEEK_FRONT;
         end
         ST_PEEK_FRONT: begin
            mem_ra   = '0;
            state_in = ST_PEEK_BACK;
         end
         ST_PEEK_BACK: begin
            front_in = mem_rd;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = ENTRY_COUNT_W'(count_ff);
               rsp_empty_in = empty;
               rsp_err_in   = err_ff;
               rsp_front_in = empty ? '0 : front_ff;
               rsp_back_in  = empty ? '0 : mem_rd;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      src_ff       <= src_in;
      up_ff        <= up_in;
      ins_ff       <= ins_in;
      pend_dst_ff  <= pend_dst_in;
      place_idx_ff <= place_idx_in;
      new_rec_ff   <= new_rec_in;
      front_ff     <= front_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_front_ff <= rsp_front_in;
      rsp_back_ff  <= rsp_back_in;
      if (req_acc) err_ff <= err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_front_card    = rsp_front_ff.card;
   assign rsp_front_balance = rsp_front_ff.balance;
   assign rsp_back_card     = rsp_back_ff.card;
   assign rsp_back_balance  = rsp_back_ff.balance;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("record count above list depth");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_MOVE || state_ff == ST_PLACE))
      else $error("record RAM written outside shift or place");

   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      (req_acc && err_in != ERR_OK) |=> count_ff == $past(count_ff))
      else $error("failed request changed the count");

   a_move_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && state_in != ST_MOVE) |-> (left_ff == '0 && !pend_vld_ff))
      else $error("shift left with beats still pending");

   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == '0)))
      else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire
